@@ rtl/hq_pkg.sv @@
// Shared types, sizes and codes for the binary min-heap priority queue.
package hq_pkg;

  // Storage sizes
  localparam int HEAP_DEPTH = 1024;
  localparam int KEY_BITS   = 32;
  localparam int TAG_BITS   = 16;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  // Wide enough for a child index of any slot
  localparam int WIDE_W     = CNT_W + 1;

  // Operation codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One stored heap entry
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Input item
  typedef struct packed {
    logic                action;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0]          status;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic [CNT_W-1:0]    fill;
  } out_item_t;

endpackage

@@ rtl/hq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

@@ rtl/binary_min_heap_queue.sv @@
// Top level of the binary min-heap priority queue: sequencer, compare unit and heap RAM.
//
// Usage: drive in_item and raise start while busy is low; the item is taken at
// that clock edge and busy rises on the next cycle unless it is refused. An
// item either pushes a (key, tag) entry or pops the entry with the smallest
// key. Exactly one result item follows each input item: out_valid is high for
// one cycle with out_item holding status, popped key and tag (zero unless a pop
// succeeded) and the fill level after the operation. busy falls in the same
// cycle that out_valid is shown, so the next item may be started then.
// Work is paced by the single-read-port heap RAM and the one shared key
// comparator: a push reads the parent, compares and writes once per level
// climbed, and a final write settles the entry at the root or below; a pop
// reads the root and the last entry, then per level descended reads the left
// child, compares it and reads the right child, compares and writes, until
// the entry settles at a leaf or above one. A pop that empties the heap ends
// after the root read. Refused pushes and pops on an empty heap do not leave idle.
// Reset clears only the count, state and out_valid; the heap is empty at once
// and no clearing pass runs. The receiver cannot stall: each result is offered once.
module binary_min_heap_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hq_pkg::in_item_t     in_item,
  output logic                 out_valid,
  output hq_pkg::out_item_t    out_item
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SU_RD   = 3'd1;
  localparam logic [2:0] ST_SU_CMP  = 3'd2;
  localparam logic [2:0] ST_PO_ROOT = 3'd3;
  localparam logic [2:0] ST_PO_LAST = 3'd4;
  localparam logic [2:0] ST_SD_L    = 3'd5;
  localparam logic [2:0] ST_SD_R    = 3'd6;
  localparam logic [2:0] ST_SD_CMP  = 3'd7;

  logic [2:0]                   state_r, state_nxt;
  logic [hq_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [hq_pkg::ADDR_W-1:0]    pos_r, pos_nxt;
  hq_pkg::entry_t               ent_r, ent_nxt;
  hq_pkg::entry_t               best_r, best_nxt;
  logic                         best_left_r, best_left_nxt;
  logic                         has_right_r, has_right_nxt;
  logic [1:0]                   res_status_r, res_status_nxt;
  logic [hq_pkg::KEY_BITS-1:0]  res_key_r, res_key_nxt;
  logic [hq_pkg::TAG_BITS-1:0]  res_tag_r, res_tag_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                         ram_we;
  logic [hq_pkg::ADDR_W-1:0]    ram_waddr;
  hq_pkg::entry_t               ram_wdata;
  logic [hq_pkg::ADDR_W-1:0]    ram_raddr;
  logic [hq_pkg::ENTRY_W-1:0]   ram_rdata;
  hq_pkg::entry_t               rd_ent;

  logic [hq_pkg::KEY_BITS-1:0]  cmp_a, cmp_b;
  logic                         cmp_lt;

  logic [hq_pkg::ADDR_W-1:0]    parent_idx;
  logic [hq_pkg::WIDE_W-1:0]    lc_w, rc_w, count_w;

  hq_ram #(
    .WIDTH (hq_pkg::ENTRY_W),
    .DEPTH (hq_pkg::HEAP_DEPTH)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_ent = hq_pkg::entry_t'(ram_rdata);

  // Index arithmetic for parent and children of the current slot
  assign parent_idx = hq_pkg::ADDR_W'((pos_r - 1'b1) >> 1);
  assign lc_w       = (hq_pkg::WIDE_W'(pos_r) << 1) | hq_pkg::WIDE_W'(1);
  assign rc_w       = lc_w + hq_pkg::WIDE_W'(1);
  assign count_w    = hq_pkg::WIDE_W'(count_r);

  // Shared key comparator: operands depend on the step
  always_comb begin
    cmp_a = rd_ent.key;
    cmp_b = best_r.key;
    if (state_r == ST_SU_CMP) begin
      cmp_a = ent_r.key;
      cmp_b = rd_ent.key;
    end else if (state_r == ST_SD_R) begin
      cmp_b = ent_r.key;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    ent_nxt        = ent_r;
    best_nxt       = best_r;
    best_left_nxt  = best_left_r;
    has_right_nxt  = has_right_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    out_valid_nxt  = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = ent_r;
    ram_raddr      = parent_idx;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          res_key_nxt    = '0;
          res_tag_nxt    = '0;
          res_status_nxt = hq_pkg::STATUS_OK;
          if (in_item.action == hq_pkg::ACT_PUSH) begin
            if (count_r == hq_pkg::CNT_W'(hq_pkg::HEAP_DEPTH)) begin
              res_status_nxt = hq_pkg::STATUS_FULL;
              out_valid_nxt  = 1'b1;
            end else begin
              pos_nxt     = count_r[hq_pkg::ADDR_W-1:0];
              ent_nxt.key = in_item.key;
              ent_nxt.tag = in_item.tag;
              count_nxt   = count_r + 1'b1;
              state_nxt   = ST_SU_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = hq_pkg::STATUS_EMPTY;
              out_valid_nxt  = 1'b1;
            end else begin
              ram_raddr = '0;
              count_nxt = count_r - 1'b1;
              state_nxt = ST_PO_ROOT;
            end
          end
        end
      end

      // Sift up: fetch parent, or settle at the root
      ST_SU_RD: begin
        if (pos_r == '0) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_SU_CMP;
        end
      end

      // Sift up: move parent down if new key is strictly smaller
      ST_SU_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = rd_ent;
          pos_nxt   = parent_idx;
          state_nxt = ST_SU_RD;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      // Pop: root arrives; fetch the last entry
      ST_PO_ROOT: begin
        res_key_nxt = rd_ent.key;
        res_tag_nxt = rd_ent.tag;
        ram_raddr   = count_r[hq_pkg::ADDR_W-1:0];
        if (count_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_PO_LAST;
        end
      end

      ST_PO_LAST: begin
        ent_nxt   = rd_ent;
        pos_nxt   = '0;
        state_nxt = ST_SD_L;
      end

      // Sift down: fetch left child, or settle if leaf
      ST_SD_L: begin
        ram_raddr = lc_w[hq_pkg::ADDR_W-1:0];
        if (lc_w >= count_w) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_SD_R;
        end
      end

      // Sift down: left child against moving entry; fetch right child
      ST_SD_R: begin
        ram_raddr     = rc_w[hq_pkg::ADDR_W-1:0];
        best_nxt      = cmp_lt ? rd_ent : ent_r;
        best_left_nxt = cmp_lt;
        has_right_nxt = rc_w < count_w;
        state_nxt     = ST_SD_CMP;
      end

      // Sift down: right child against current pick, then move
      ST_SD_CMP: begin
        ram_we = 1'b1;
        if (has_right_r && cmp_lt) begin
          ram_wdata = rd_ent;
          pos_nxt   = rc_w[hq_pkg::ADDR_W-1:0];
          state_nxt = ST_SD_L;
        end else if (best_left_r) begin
          ram_wdata = best_r;
          pos_nxt   = lc_w[hq_pkg::ADDR_W-1:0];
          state_nxt = ST_SD_L;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    ent_r        <= ent_nxt;
    best_r       <= best_nxt;
    best_left_r  <= best_left_nxt;
    has_right_r  <= has_right_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
  end

  // Outputs
  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_item.status  = res_status_r;
  assign out_item.out_key = res_key_r;
  assign out_item.out_tag = res_tag_r;
  assign out_item.fill    = count_r;

endmodule
